[hdl/binned_weighted_class_sum_macros.svh]
// -----------------------------------------------------------------------------
// binned_weighted_class_sum_macros
// Assertion macros used by the accumulator RTL.
// -----------------------------------------------------------------------------
`ifndef BINNED_WEIGHTED_CLASS_SUM_MACROS_SVH
`define BINNED_WEIGHTED_CLASS_SUM_MACROS_SVH

// same-cycle implication
`define BWCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bwcs: same-cycle check failed");

// next-cycle implication
`define BWCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bwcs: next-cycle check failed");

`endif

[hdl/bwcs_pkg.sv]
// -----------------------------------------------------------------------------
// bwcs_pkg
// Types, codes, land-class fractions and saturating helpers.
// -----------------------------------------------------------------------------
package bwcs_pkg;

    localparam int REQ_W    = 2;
    localparam int PIX_W    = 16;
    localparam int BIN_W    = 16;
    localparam int FLAG_W   = 8;
    localparam int CLASS_W  = 8;
    localparam int FRAC_W   = 16;
    localparam int WEIGHT_W = 32;
    localparam int SUM_W    = 63;
    localparam int CNT_W    = 32;

    localparam logic [REQ_W-1:0] REQ_ACCUM = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CLASS_W-1:0] CLS_40  = 8'd40;
    localparam logic [CLASS_W-1:0] CLS_50  = 8'd50;
    localparam logic [CLASS_W-1:0] CLS_60  = 8'd60;
    localparam logic [CLASS_W-1:0] CLS_70  = 8'd70;
    localparam logic [CLASS_W-1:0] CLS_90  = 8'd90;
    localparam logic [CLASS_W-1:0] CLS_100 = 8'd100;
    localparam logic [CLASS_W-1:0] CLS_160 = 8'd160;

    localparam logic [FRAC_W-1:0] FRAC_0P48  = 16'd31457;
    localparam logic [FRAC_W-1:0] FRAC_0P51  = 16'd33423;
    localparam logic [FRAC_W-1:0] FRAC_0P495 = 16'd32440;
    localparam logic [FRAC_W-1:0] FRAC_0P47  = 16'd30802;
    localparam logic [FRAC_W-1:0] FRAC_HALF  = 16'd32768;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [SUM_W-1:0] fsum;
        logic [CNT_W-1:0] fcnt;
        logic [SUM_W-1:0] nsum;
        logic [CNT_W-1:0] ncnt;
    } t_bin_entry;

    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic                in_range;
        logic                accum;
        logic                forest;
        logic [WEIGHT_W-1:0] weight;
    } t_stage;

    typedef struct packed {
        t_bin_entry       bin;
        logic [SUM_W-1:0] afsum;
        logic [CNT_W-1:0] afcnt;
        logic [SUM_W-1:0] ansum;
        logic [CNT_W-1:0] ancnt;
        logic             oor;
    } t_result;

    function automatic logic [FRAC_W-1:0] class_fraction(input logic ovr,
                                                         input logic [CLASS_W-1:0] cls);
        logic [FRAC_W-1:0] f;
        case (cls) inside
            CLS_40, CLS_50, CLS_60, CLS_160: f = FRAC_0P48;
            CLS_70, CLS_90:                  f = FRAC_0P51;
            CLS_100:                         f = FRAC_0P495;
            default:                         f = FRAC_0P47;
        endcase
        return ovr ? FRAC_HALF : f;
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [WEIGHT_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a);
        return (a == CNT_MAX) ? CNT_MAX : a + 1'b1;
    endfunction

endpackage

[hdl/bwcs_if.sv]
// -----------------------------------------------------------------------------
// bwcs_if
// Valid/ready channels for request items and result items.
// -----------------------------------------------------------------------------
interface bwcs_req_if;
    import bwcs_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [PIX_W-1:0]   pixel_value;
    logic [BIN_W-1:0]   bin_index;
    logic [FLAG_W-1:0]  forest_flag;
    logic [CLASS_W-1:0] land_class;

    modport source (output valid, output req_type, output pixel_value, output bin_index,
                    output forest_flag, output land_class, input ready);
    modport sink   (input valid, input req_type, input pixel_value, input bin_index,
                    input forest_flag, input land_class, output ready);
endinterface

interface bwcs_res_if;
    import bwcs_pkg::*;

    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] bin_forest_sum;
    logic [CNT_W-1:0] bin_forest_pixels;
    logic [SUM_W-1:0] bin_nonforest_sum;
    logic [CNT_W-1:0] bin_nonforest_pixels;
    logic [SUM_W-1:0] all_forest_sum;
    logic [CNT_W-1:0] all_forest_pixels;
    logic [SUM_W-1:0] all_nonforest_sum;
    logic [CNT_W-1:0] all_nonforest_pixels;
    logic             bin_out_of_range;

    modport source (output valid, output bin_forest_sum, output bin_forest_pixels,
                    output bin_nonforest_sum, output bin_nonforest_pixels,
                    output all_forest_sum, output all_forest_pixels,
                    output all_nonforest_sum, output all_nonforest_pixels,
                    output bin_out_of_range, input ready);
    modport sink   (input valid, input bin_forest_sum, input bin_forest_pixels,
                    input bin_nonforest_sum, input bin_nonforest_pixels,
                    input all_forest_sum, input all_forest_pixels,
                    input all_nonforest_sum, input all_nonforest_pixels,
                    input bin_out_of_range, output ready);
endinterface

[hdl/bwcs_ram.sv]
// -----------------------------------------------------------------------------
// bwcs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// -----------------------------------------------------------------------------
module bwcs_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 16,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/bwcs_accum.sv]
// -----------------------------------------------------------------------------
// bwcs_accum
// Read-modify-write stage: bin merge with forwarding, valid bits, global sums.
// -----------------------------------------------------------------------------
`include "binned_weighted_class_sum_macros.svh"

module bwcs_accum #(
    parameter int BIN_COUNT = 256,
    parameter int AW        = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  bwcs_pkg::t_stage     i_stage,
    input  logic [AW-1:0]        i_addr,
    input  bwcs_pkg::t_bin_entry i_rdata,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output bwcs_pkg::t_bin_entry o_wdata,
    output bwcs_pkg::t_result    o_result
);
    import bwcs_pkg::*;

    logic [BIN_COUNT-1:0] r_valid;
    logic                 r_wb_valid;
    logic [AW-1:0]        r_wb_addr;
    t_bin_entry           r_wb_data;
    logic [SUM_W-1:0]     r_gf_sum;
    logic [CNT_W-1:0]     r_gf_cnt;
    logic [SUM_W-1:0]     r_gn_sum;
    logic [CNT_W-1:0]     r_gn_cnt;

    t_bin_entry old_entry;
    t_bin_entry new_entry;
    logic       fwd_hit;
    logic       do_write;
    logic       do_clear;

    assign fwd_hit  = r_wb_valid && (r_wb_addr == i_addr);
    assign do_write = i_advance && i_stage.accum;
    assign do_clear = i_advance && (i_stage.req == REQ_CLEAR);

    always_comb begin
        if (!i_stage.in_range || !r_valid[i_addr]) begin
            old_entry = '0;
        end else if (fwd_hit) begin
            old_entry = r_wb_data;
        end else begin
            old_entry = i_rdata;
        end
        new_entry = old_entry;
        if (i_stage.forest) begin
            new_entry.fsum = sat_sum(old_entry.fsum, i_stage.weight);
            new_entry.fcnt = sat_cnt(old_entry.fcnt);
        end else begin
            new_entry.nsum = sat_sum(old_entry.nsum, i_stage.weight);
            new_entry.ncnt = sat_cnt(old_entry.ncnt);
        end
    end

    always_comb begin
        o_result.bin   = i_stage.in_range ? old_entry : '0;
        o_result.oor   = !i_stage.in_range;
        o_result.afsum = r_gf_sum;
        o_result.afcnt = r_gf_cnt;
        o_result.ansum = r_gn_sum;
        o_result.ancnt = r_gn_cnt;
    end

    assign o_we    = do_write;
    assign o_waddr = i_addr;
    assign o_wdata = new_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_wb_valid <= 1'b0;
            r_gf_sum   <= '0;
            r_gf_cnt   <= '0;
            r_gn_sum   <= '0;
            r_gn_cnt   <= '0;
        end else if (do_clear) begin
            r_valid    <= '0;
            r_wb_valid <= 1'b0;
            r_gf_sum   <= '0;
            r_gf_cnt   <= '0;
            r_gn_sum   <= '0;
            r_gn_cnt   <= '0;
        end else if (i_advance) begin
            r_wb_valid <= do_write;
            if (do_write) begin
                r_valid[i_addr] <= 1'b1;
                if (i_stage.forest) begin
                    r_gf_sum <= sat_sum(r_gf_sum, i_stage.weight);
                    r_gf_cnt <= sat_cnt(r_gf_cnt);
                end else begin
                    r_gn_sum <= sat_sum(r_gn_sum, i_stage.weight);
                    r_gn_cnt <= sat_cnt(r_gn_cnt);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_wb_addr <= i_addr;
            r_wb_data <= new_entry;
        end
    end

    `BWCS_ASSERT_NEXT(a_gf_cnt_mono, i_clk, i_rst_n, i_advance && !do_clear, r_gf_cnt >= $past(r_gf_cnt))
    `BWCS_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, do_clear, r_valid == '0 && r_gf_sum == '0 && r_gn_cnt == '0)
    `BWCS_ASSERT_NOW(a_write_counts, i_clk, i_rst_n, do_write, new_entry.fcnt >= old_entry.fcnt && new_entry.ncnt >= old_entry.ncnt && i_stage.in_range)

endmodule

[hdl/binned_weighted_class_sum.sv]
// -----------------------------------------------------------------------------
// binned_weighted_class_sum
// Zonal weighted histogram with forest / non-forest split and global sums.
// -----------------------------------------------------------------------------
// Takes one request item per clock while nothing holds it: accumulate, read or
// clear. The bin sums live in one RAM word per bin, read when the item is
// taken and merged and written back in the next cycle; a write still landing
// in the RAM is forwarded to the item right behind it, so repeated bins run at
// full rate. Clear works through per-bin valid bits, with no RAM writes. A read
// item holds the pipeline only while the result register is full and not taken.
// -----------------------------------------------------------------------------
module binned_weighted_class_sum #(
    parameter int BIN_COUNT  = 256,
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bwcs_req_if.sink    i_req,
    bwcs_res_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);
    import bwcs_pkg::*;

    localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int VB = (VALUE_BITS < PIX_W) ? VALUE_BITS : PIX_W;
    localparam logic [PIX_W:0]   VAL_LIM  = (PIX_W+1)'(1) << VB;
    localparam logic [PIX_W-1:0] VAL_MASK = PIX_W'(VAL_LIM - 1'b1);
    localparam logic [BIN_W:0]   BIN_LIM  = (BIN_W+1)'(BIN_COUNT);

    logic              r_override;
    t_stage            r_s1;
    logic              r_s1_valid;
    logic [AW-1:0]     r_s1_addr;
    t_result           r_out;
    logic              r_out_valid;

    logic [PIX_W-1:0]  s0_val;
    logic [FRAC_W-1:0] s0_frac;
    t_stage            s0_stage;
    logic              accept;
    logic              s1_advance;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_bin_entry        ram_wdata;
    t_bin_entry        ram_rdata;
    t_result           s1_result;

    assign s0_val  = i_req.pixel_value & VAL_MASK;
    assign s0_frac = class_fraction(r_override, i_req.land_class);

    always_comb begin
        s0_stage.req      = i_req.req_type;
        s0_stage.in_range = {1'b0, i_req.bin_index} < BIN_LIM;
        s0_stage.forest   = |i_req.forest_flag;
        s0_stage.accum    = (i_req.req_type == REQ_ACCUM) && (s0_val != '0) &&
                            s0_stage.in_range;
        s0_stage.weight   = WEIGHT_W'(s0_val) * WEIGHT_W'(s0_frac);
    end

    assign s1_advance  = r_s1_valid &&
                         ((r_s1.req != REQ_READ) || !r_out_valid || o_res.ready);
    assign i_req.ready = !r_s1_valid || s1_advance;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_override  <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_override <= i_cfg_wdata;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance && (r_s1.req == REQ_READ)) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1      <= s0_stage;
            r_s1_addr <= AW'(i_req.bin_index);
        end
        if (s1_advance && (r_s1.req == REQ_READ)) begin
            r_out <= s1_result;
        end
    end

    bwcs_ram #(
        .WIDTH ($bits(t_bin_entry)),
        .DEPTH (BIN_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (AW'(i_req.bin_index)),
        .o_rdata (ram_rdata)
    );

    bwcs_accum #(
        .BIN_COUNT (BIN_COUNT),
        .AW        (AW)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s1_advance),
        .i_stage   (r_s1),
        .i_addr    (r_s1_addr),
        .i_rdata   (ram_rdata),
        .o_we      (ram_we),
        .o_waddr   (ram_waddr),
        .o_wdata   (ram_wdata),
        .o_result  (s1_result)
    );

    assign o_res.valid                = r_out_valid;
    assign o_res.bin_forest_sum       = r_out.bin.fsum;
    assign o_res.bin_forest_pixels    = r_out.bin.fcnt;
    assign o_res.bin_nonforest_sum    = r_out.bin.nsum;
    assign o_res.bin_nonforest_pixels = r_out.bin.ncnt;
    assign o_res.all_forest_sum       = r_out.afsum;
    assign o_res.all_forest_pixels    = r_out.afcnt;
    assign o_res.all_nonforest_sum    = r_out.ansum;
    assign o_res.all_nonforest_pixels = r_out.ancnt;
    assign o_res.bin_out_of_range     = r_out.oor;

endmodule
